// File: sv/rct_pkg.sv
// shared types, codes and constants of the reassembly context table
package rct_pkg;

   // defaults and fixed field widths
   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS       = 16;
   localparam int CMD_W             = 2;
   localparam int ID_W              = 32;
   localparam int SLOT_W            = 4;
   localparam int TIME_W            = 32;
   localparam int STATUS_W          = 3;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

   // request commands
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTPRES = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd6;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic do_get;
      logic do_remove;
      logic sw_start;
      logic sw_capture;
      logic sw_next;
      logic sw_finish;
   } rct_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
      logic evict;
      logic pend_valid;
      logic idx_last;
      logic cnt_full_next;
   } rct_stat_type;

endpackage

// File: sv/rct_ram.sv
// generic single write port ram with registered read
module rct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rct_ctrl.sv
// controller state machine of the reassembly context table
module rct_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [rct_pkg::CMD_W-1:0]   req_cmd,
   output logic                        req_ready,
   input  rct_pkg::rct_stat_type       stat,
   output rct_pkg::rct_cmd_type        cmd
);
   import rct_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_GET    = 3'd1;
   localparam logic [2:0] S_REMOVE = 3'd2;
   localparam logic [2:0] S_SW_RD  = 3'd3;
   localparam logic [2:0] S_SW_CHK = 3'd4;
   localparam logic [2:0] S_SW_END = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_cmd)
                  CMD_GET:    state_in = S_GET;
                  CMD_REMOVE: state_in = S_REMOVE;
                  CMD_SWEEP: begin
                     cmd.sw_start = 1'b1;
                     state_in     = S_SW_RD;
                  end
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_GET: begin
            if (stat.out_free) begin
               cmd.do_get = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_REMOVE: begin
            if (stat.out_free) begin
               cmd.do_remove = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SW_RD: begin
            state_in = S_SW_CHK;
         end
         S_SW_CHK: begin
            if (stat.evict) begin
               // a held eviction must leave before the new one is taken
               if (!stat.pend_valid || stat.out_free) begin
                  cmd.sw_capture = 1'b1;
                  if (stat.idx_last || stat.cnt_full_next) begin
                     state_in = S_SW_END;
                  end else begin
                     cmd.sw_next = 1'b1;
                     state_in    = S_SW_RD;
                  end
               end
            end else if (stat.idx_last) begin
               state_in = S_SW_END;
            end else begin
               cmd.sw_next = 1'b1;
               state_in    = S_SW_RD;
            end
         end
         S_SW_END: begin
            if (stat.out_free) begin
               cmd.sw_finish = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a result is only produced when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_get || cmd.do_remove || cmd.sw_finish) |-> stat.out_free)
      else $error("result produced into a busy output register");

   // pushing a held eviction also needs the output register
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.sw_capture && stat.pend_valid) |-> stat.out_free)
      else $error("held eviction pushed into a busy output register");

   // a sweep always ends with a final response
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_END && stat.out_free) |=> (state_ff == S_IDLE))
      else $error("sweep did not close");

endmodule

// File: sv/rct_dp.sv
// datapath of the reassembly context table: id match, slot state, sweep scan
module rct_dp #(
   parameter int NUM_SLOTS = rct_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rct_pkg::rct_cmd_type           cmd,
   output rct_pkg::rct_stat_type          stat,
   input  logic [rct_pkg::ID_W-1:0]       req_buf_id,
   input  logic [rct_pkg::SLOT_W-1:0]     req_slot_in,
   input  logic [rct_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           csr_wr_en,
   input  logic [rct_pkg::TIME_W-1:0]     csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rct_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rct_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [rct_pkg::ID_W-1:0]       rsp_id_out,
   output logic                           rsp_last
);
   import rct_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   // request registers
   logic [ID_W-1:0]   buf_id_ff,  buf_id_in;
   logic [SLOT_W-1:0] slot_in_ff, slot_in_in;
   logic [TIME_W-1:0] now_ff,     now_in;
   logic [TIME_W-1:0] timeout_ff, timeout_in;

   // table state
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]      id_ff [NUM_SLOTS];
   logic [ID_W-1:0]      id_in [NUM_SLOTS];

   // sweep scan state
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;

   // lookup and misc
   logic [NUM_SLOTS-1:0] match;
   logic                 hit;
   logic                 any_free;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     rm_idx;
   logic                 rm_ok;
   logic [IDX_W-1:0]     id_rd_idx;
   logic [ID_W-1:0]      id_rd;
   logic [TIME_W-1:0]    stamp_rd;
   logic [TIME_W-1:0]    age;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic                 emit;

   // use stamps live in a ram, read only by the sweep
   rct_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_SLOTS)
   ) u_stamp (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (now_ff),
      .rd_addr (idx_ff),
      .rd_data (stamp_rd)
   );

   // parallel id match and lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         match[i] = valid_ff[i] && (id_ff[i] == buf_id_ff);
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      hit      = |match;
      any_free = ~&valid_ff;
   end

   // remove target and the single id read port
   assign rm_idx    = IDX_W'(slot_in_ff);
   assign rm_ok     = (int'(slot_in_ff) < NUM_SLOTS) && valid_ff[rm_idx];
   assign id_rd_idx = cmd.do_remove ? rm_idx : idx_ff;
   assign id_rd     = id_ff[id_rd_idx];

   // sweep age check
   assign age = now_ff - stamp_rd;

   // status to the controller
   always_comb begin
      stat.out_free      = !rsp_valid_ff || rsp_ready;
      stat.evict         = valid_ff[idx_ff] && (age > timeout_ff);
      stat.pend_valid    = pend_valid_ff;
      stat.idx_last      = (idx_ff == IDX_W'(NUM_SLOTS - 1));
      stat.cnt_full_next = (cnt_ff == CNT_W'(MAX_RESULTS - 1));
   end

   // next values
   always_comb begin
      buf_id_in     = buf_id_ff;
      slot_in_in    = slot_in_ff;
      now_in        = now_ff;
      timeout_in    = timeout_ff;
      valid_in      = valid_ff;
      id_in         = id_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_id_in    = pend_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = hit_idx;
      emit          = 1'b0;

      // configuration write
      if (csr_wr_en) begin
         timeout_in = csr_wr_data;
      end

      // capture the request
      if (cmd.load_req) begin
         buf_id_in  = req_buf_id;
         slot_in_in = req_slot_in;
         now_in     = req_now_ms;
      end

      // get: hit, allocate or full
      if (cmd.do_get) begin
         emit        = 1'b1;
         rsp_last_in = 1'b1;
         rsp_id_in   = buf_id_ff;
         if (hit) begin
            ram_we        = 1'b1;
            ram_waddr     = hit_idx;
            rsp_status_in = ST_HIT;
            rsp_slot_in   = SLOT_W'(hit_idx);
         end else if (any_free) begin
            ram_we            = 1'b1;
            ram_waddr         = free_idx;
            valid_in[free_idx] = 1'b1;
            id_in[free_idx]    = buf_id_ff;
            rsp_status_in     = ST_ALLOC;
            rsp_slot_in       = SLOT_W'(free_idx);
         end else begin
            rsp_status_in = ST_FULL;
            rsp_slot_in   = '0;
         end
      end

      // remove
      if (cmd.do_remove) begin
         emit        = 1'b1;
         rsp_last_in = 1'b1;
         rsp_slot_in = slot_in_ff;
         if (rm_ok) begin
            valid_in[rm_idx] = 1'b0;
            rsp_status_in    = ST_REMOVED;
            rsp_id_in        = id_rd;
         end else begin
            rsp_status_in = ST_NOTPRES;
            rsp_id_in     = '0;
         end
      end

      // sweep start
      if (cmd.sw_start) begin
         idx_in        = '0;
         cnt_in        = '0;
         pend_valid_in = 1'b0;
      end

      // eviction: push the held one out, hold the new one
      if (cmd.sw_capture) begin
         if (pend_valid_ff) begin
            emit          = 1'b1;
            rsp_status_in = ST_EVICTED;
            rsp_slot_in   = SLOT_W'(pend_slot_ff);
            rsp_id_in     = pend_id_ff;
            rsp_last_in   = 1'b0;
         end
         valid_in[idx_ff] = 1'b0;
         pend_valid_in    = 1'b1;
         pend_slot_in     = idx_ff;
         pend_id_in       = id_rd;
         cnt_in           = cnt_ff + 1'b1;
      end

      if (cmd.sw_next) begin
         idx_in = idx_ff + 1'b1;
      end

      // final sweep response
      if (cmd.sw_finish) begin
         emit        = 1'b1;
         rsp_last_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_status_in = ST_EVICTED;
            rsp_slot_in   = SLOT_W'(pend_slot_ff);
            rsp_id_in     = pend_id_ff;
         end else begin
            rsp_status_in = ST_NONE;
            rsp_slot_in   = '0;
            rsp_id_in     = '0;
         end
         pend_valid_in = 1'b0;
      end

      // output valid
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         timeout_ff    <= timeout_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      buf_id_ff     <= buf_id_in;
      slot_in_ff    <= slot_in_in;
      now_ff        <= now_in;
      id_ff         <= id_in;
      pend_slot_ff  <= pend_slot_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_id_out   = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

   // one sweep never evicts more than the result limit
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("sweep eviction count over limit");

   // an empty sweep response is always final
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NONE) |-> rsp_last_ff)
      else $error("empty sweep response without last");

   // an allocated slot is valid afterwards
   a_alloc_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_get && !hit && any_free) |=> valid_ff[$past(free_idx)])
      else $error("allocated slot not marked valid");

endmodule

// File: sv/reassembly_context_table.sv
// reassembly context table: get/allocate by id, remove by slot, timeout sweep
// response: get and remove each load a single response into the output register once it is free
// requests: taken only in idle, so a new one waits until the last has loaded its response
// sweep: each slot passes the read and check states, at most sixteen evictions per request
// reset: all slots invalid and timeout at 1000 ms at once, no clearing pass
module reassembly_context_table #(
   parameter int NUM_SLOTS = rct_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rct_pkg::CMD_W-1:0]      req_cmd,
   input  logic [rct_pkg::ID_W-1:0]       req_buf_id,
   input  logic [rct_pkg::SLOT_W-1:0]     req_slot_in,
   input  logic [rct_pkg::TIME_W-1:0]     req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rct_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rct_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [rct_pkg::ID_W-1:0]       rsp_id_out,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [rct_pkg::TIME_W-1:0]     csr_wr_data
);
   import rct_pkg::*;

   rct_cmd_type  dp_cmd;
   rct_stat_type dp_stat;

   // controller
   rct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // datapath
   rct_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .stat         (dp_stat),
      .req_buf_id   (req_buf_id),
      .req_slot_in  (req_slot_in),
      .req_now_ms   (req_now_ms),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_slot_out (rsp_slot_out),
      .rsp_id_out   (rsp_id_out),
      .rsp_last     (rsp_last)
   );

endmodule

// File: tb/rct_checker.sv
// response checker for the reassembly context table: table prediction and in-order compare
`timescale 1ns / 100ps
module rct_checker #(
   parameter int NUM_SLOTS = rct_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [rct_pkg::CMD_W-1:0]      req_cmd,
   input  logic [rct_pkg::ID_W-1:0]       req_buf_id,
   input  logic [rct_pkg::SLOT_W-1:0]     req_slot_in,
   input  logic [rct_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [rct_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [rct_pkg::SLOT_W-1:0]     rsp_slot_out,
   input  logic [rct_pkg::ID_W-1:0]       rsp_id_out,
   input  logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [rct_pkg::TIME_W-1:0]     csr_wr_data,
   output int                             fail_count,
   output int                             pending
);
   import rct_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     id;
      logic                last;
   } ctx_rsp_type;

   // expected responses, oldest first
   ctx_rsp_type       due_rsp[$];

   // shadow copy of the context table and the stall timeout
   logic              ctx_valid [NUM_SLOTS];
   logic [ID_W-1:0]   ctx_id    [NUM_SLOTS];
   logic [TIME_W-1:0] ctx_stamp [NUM_SLOTS];
   logic [TIME_W-1:0] stall_limit;

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("%0t ns rct_checker: %s", $time, msg);
      fail_count++;
   endtask

   function automatic ctx_rsp_type mk_rsp(input logic [STATUS_W-1:0] status, input int slot,
         input logic [ID_W-1:0] id, input logic last);
      ctx_rsp_type r;
      r.status = status;
      r.slot   = SLOT_W'(slot);
      r.id     = id;
      r.last   = last;
      return r;
   endfunction

   // work out the responses of one accepted request and update the table
   task automatic predict_table_rsp(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
         input logic [SLOT_W-1:0] sin, input logic [TIME_W-1:0] now);
      int                i;
      int                hit;
      int                free;
      int                n;
      logic [TIME_W-1:0] age;
      ctx_rsp_type       r;
      hit  = -1;
      free = -1;
      n    = 0;
      case (cmd)
         CMD_GET: begin
            // lowest matching slot wins, else lowest free slot
            for (i = 0; i < NUM_SLOTS; i++) begin
               if (ctx_valid[i] && ctx_id[i] == id && hit < 0)
                  hit = i;
               if (!ctx_valid[i] && free < 0)
                  free = i;
            end
            if (hit >= 0) begin
               ctx_stamp[hit] = now;
               due_rsp.push_back(mk_rsp(ST_HIT, hit, id, 1'b1));
            end else if (free < 0) begin
               due_rsp.push_back(mk_rsp(ST_FULL, 0, id, 1'b1));
            end else begin
               ctx_valid[free] = 1'b1;
               ctx_id[free]    = id;
               ctx_stamp[free] = now;
               due_rsp.push_back(mk_rsp(ST_ALLOC, free, id, 1'b1));
            end
         end
         CMD_REMOVE: begin
            if (int'(sin) < NUM_SLOTS && ctx_valid[sin]) begin
               ctx_valid[sin] = 1'b0;
               due_rsp.push_back(mk_rsp(ST_REMOVED, int'(sin), ctx_id[sin], 1'b1));
            end else begin
               due_rsp.push_back(mk_rsp(ST_NOTPRES, int'(sin), '0, 1'b1));
            end
         end
         CMD_SWEEP: begin
            // evict stalled slots, lowest first, bounded per request
            for (i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++) begin
               age = now - ctx_stamp[i];
               if (ctx_valid[i] && age > stall_limit) begin
                  ctx_valid[i] = 1'b0;
                  due_rsp.push_back(mk_rsp(ST_EVICTED, i, ctx_id[i], 1'b0));
                  n++;
               end
            end
            if (n == 0) begin
               due_rsp.push_back(mk_rsp(ST_NONE, 0, '0, 1'b1));
            end else begin
               r      = due_rsp.pop_back();
               r.last = 1'b1;
               due_rsp.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [ID_W-1:0] got,
         input logic [ID_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // compare one accepted response with the oldest expectation
   task automatic check_rsp();
      ctx_rsp_type want;
      if (due_rsp.size() == 0) begin
         report_mismatch($sformatf("unexpected response status %0d slot %0d id %0h last %0b",
            rsp_status, rsp_slot_out, rsp_id_out, rsp_last));
      end else begin
         want = due_rsp.pop_front();
         compare_field("status", ID_W'(rsp_status), ID_W'(want.status));
         compare_field("slot_out", ID_W'(rsp_slot_out), ID_W'(want.slot));
         compare_field("id_out", rsp_id_out, want.id);
         compare_field("last", ID_W'(rsp_last), ID_W'(want.last));
      end
   endtask

   // sample both channels and the register port at the rising edge
   always @(posedge clock) begin : sample
      int i;
      if (reset) begin
         for (i = 0; i < NUM_SLOTS; i++) begin
            ctx_valid[i] = 1'b0;
            ctx_id[i]    = '0;
            ctx_stamp[i] = '0;
         end
         stall_limit = TIMEOUT_RESET;
         due_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_rsp();
         if (req_valid && req_ready)
            predict_table_rsp(req_cmd, req_buf_id, req_slot_in, req_now_ms);
         if (csr_wr_en)
            stall_limit = csr_wr_data;
      end
      pending = due_rsp.size();
   end

endmodule

// File: tb/tb.sv
// testbench top for the reassembly context table: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
   import rct_pkg::*;

   localparam int NUM_SLOTS   = 16;
   localparam int POOL_SIZE   = 24;
   localparam int PHASE_ITEMS = 86;
   localparam int NUM_PHASES  = 5;
   localparam int SETTLE      = 8;
   localparam int IDLE_LIMIT  = 2000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd     = CMD_GET;
   logic [ID_W-1:0]     req_buf_id  = '0;
   logic [SLOT_W-1:0]   req_slot_in = '0;
   logic [TIME_W-1:0]   req_now_ms  = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [ID_W-1:0]     rsp_id_out;
   logic                rsp_last;
   logic                csr_wr_en   = 1'b0;
   logic [TIME_W-1:0]   csr_wr_data = '0;

   int                  fail_count;
   int                  pending;
   int                  idle_cycles = 0;
   int                  rx_stall    = 0;
   bit                  rx_steady   = 1'b0;
   bit                  tx_steady   = 1'b0;
   logic [TIME_W-1:0]   now_ms      = '0;
   logic [ID_W-1:0]     id_pool [POOL_SIZE];

   reassembly_context_table #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_buf_id(req_buf_id),
      .req_slot_in(req_slot_in),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out),
      .rsp_id_out(rsp_id_out),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   rct_checker #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_buf_id(req_buf_id),
      .req_slot_in(req_slot_in),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out),
      .rsp_id_out(rsp_id_out),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: stalling stretches of mostly short stalls, and stall-free stretches
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0)
         rx_steady = !rx_steady;
      if (rx_stall > 0)
         rx_stall--;
      else if (!rx_steady && $urandom_range(0, 3) == 0)
         rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      rsp_ready <= (rx_stall == 0);
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one request after a random gap and hold it until accepted
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
         input logic [SLOT_W-1:0] sin, input logic [TIME_W-1:0] now);
      int gap;
      if ($urandom_range(0, 31) == 0)
         tx_steady = !tx_steady;
      gap = 0;
      if (!tx_steady && $urandom_range(0, 1) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_buf_id  <= id;
      req_slot_in <= sin;
      req_now_ms  <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, wait for every expected response, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [TIME_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int                phase;
      int                count;
      int                j;
      int                pick;
      logic [ID_W-1:0]   req_id;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, fill to full, remove, wrapped ages
      send_request(CMD_SWEEP, '0, '0, '0);
      send_request(CMD_REMOVE, '0, 4'd0, '0);
      send_request(CMD_REMOVE, '1, 4'd15, '1);
      send_request(CMD_GET, '0, '0, 32'd0);
      send_request(CMD_GET, '1, '1, '1);
      send_request(CMD_GET, '0, '0, 32'd5);
      send_request(CMD_NONE, '1, '1, '1);
      for (j = 2; j < NUM_SLOTS; j++)
         send_request(CMD_GET, 32'h1000_0000 + j, '0, 32'd10);
      send_request(CMD_GET, 32'h1234_5678, '0, 32'd10);
      send_request(CMD_REMOVE, '0, 4'd7, 32'd10);
      send_request(CMD_SWEEP, '0, '0, 32'd2000);
      send_request(CMD_GET, 32'hA5A5_5A5A, '0, 32'd3000);
      // age equal to the timeout stays
      send_request(CMD_SWEEP, '0, '0, 32'd4000);

      // random phases, each with its own stall timeout
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case (phase)
            1: write_timeout('0);
            2: write_timeout('1);
            3: write_timeout($urandom_range(20, 400));
            4: write_timeout($urandom_range(400, 4000));
            default: ;
         endcase
         for (j = 0; j < POOL_SIZE; j++)
            id_pool[j] = $urandom;
         id_pool[0] = '0;
         id_pool[1] = '1;
         now_ms = $urandom;
         count = 0;
         while (count < PHASE_ITEMS) begin
            // time moves on, mostly in small steps
            pick = $urandom_range(0, 99);
            if (pick < 85)
               now_ms = now_ms + $urandom_range(0, 120);
            else if (pick < 98)
               now_ms = now_ms + $urandom_range(500, 5000);
            else
               now_ms = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
               req_id = ($urandom_range(0, 6) == 0) ? $urandom
                                                     : id_pool[$urandom_range(0, POOL_SIZE-1)];
               send_request(CMD_GET, req_id, SLOT_W'($urandom), now_ms);
            end else if (pick < 80) begin
               send_request(CMD_REMOVE, $urandom, SLOT_W'($urandom), now_ms);
            end else if (pick < 96) begin
               send_request(CMD_SWEEP, $urandom, SLOT_W'($urandom), now_ms);
            end else begin
               send_request(CMD_NONE, $urandom, SLOT_W'($urandom), $urandom);
               continue;
            end
            count++;
         end
      end

      settle();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
